### hdl/lmx_pkg.sv
// lmx_pkg: shared codes, widths and control structs of the mutual exclusion node
`timescale 1ns / 1ps

package lmx_pkg;

   // field widths
   localparam int MODE_W  = 3;
   localparam int SITE_F_W = 3;
   localparam int STAMP_W = 32;
   localparam int KIND_W  = 3;

   // result count per item
   localparam int MAX_RESULTS = 8;
   localparam int RES_W       = 4;

   // stamp constants
   localparam logic [STAMP_W-1:0] NONE_STAMP = 32'hFFFF_FFFF;
   localparam logic [STAMP_W-1:0] CLOCK_MAX  = 32'hFFFF_FFFE;

   // input modes
   localparam logic [MODE_W-1:0] MODE_REQUEST = 3'd0;
   localparam logic [MODE_W-1:0] MODE_REPLY   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_RELEASE = 3'd2;
   localparam logic [MODE_W-1:0] MODE_ENTER   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_EXIT    = 3'd4;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_REQUEST = 3'd0;
   localparam logic [KIND_W-1:0] KIND_REPLY   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_RELEASE = 3'd2;
   localparam logic [KIND_W-1:0] KIND_ENTERED = 3'd3;
   localparam logic [KIND_W-1:0] KIND_ERROR   = 3'd4;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic exec;
      logic scan;
      logic decide;
      logic emit;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic skip_scan;
      logic scan_done;
      logic total_zero;
      logic slot_free;
      logic emit_last;
   } sts_type;

endpackage

### hdl/lmx_req_if.sv
// lmx_req_if: input channel carrying one message or local wish per beat
`timescale 1ns / 1ps

interface lmx_req_if;
   logic                            valid;
   logic                            ready;
   logic [lmx_pkg::MODE_W-1:0]      mode;
   logic [lmx_pkg::SITE_F_W-1:0]    sender;
   logic [lmx_pkg::STAMP_W-1:0]     stamp;

   modport source (output valid, output mode, output sender, output stamp, input ready);
   modport sink   (input valid, input mode, input sender, input stamp, output ready);
endinterface

### hdl/lmx_rsp_if.sv
// lmx_rsp_if: result channel carrying one outgoing message or event per beat
`timescale 1ns / 1ps

interface lmx_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [lmx_pkg::KIND_W-1:0]      kind;
   logic [lmx_pkg::SITE_F_W-1:0]    dest;
   logic [lmx_pkg::STAMP_W-1:0]     out_stamp;
   logic                            last;

   modport source (output valid, output kind, output dest, output out_stamp, output last,
                   input ready);
   modport sink   (input valid, input kind, input dest, input out_stamp, input last,
                   output ready);
endinterface

### hdl/lmx_ctrl.sv
// lmx_ctrl: sequencer stepping each item through execute, scan (skipped on a bad site index), decide and emit
`timescale 1ns / 1ps

module lmx_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lmx_pkg::sts_type  sts,
   output lmx_pkg::cmd_type  cmd
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_EXEC   = 5'b00010,
      ST_SCAN   = 5'b00100,
      ST_DECIDE = 5'b01000,
      ST_EMIT   = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = sts.skip_scan ? ST_DECIDE : ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_done) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.total_zero) begin
               state_in = ST_IDLE;
            end else if (sts.slot_free) begin
               cmd.emit = 1'b1;
               if (sts.emit_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### hdl/lmx_dpath.sv
// lmx_dpath: node state, per-item decode, site scan and result register
`timescale 1ns / 1ps

module lmx_dpath #(
   parameter int NUM_SITES = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [lmx_pkg::SITE_F_W-1:0]       csr_wr_data,
   input  logic [lmx_pkg::MODE_W-1:0]         req_mode,
   input  logic [lmx_pkg::SITE_F_W-1:0]       req_sender,
   input  logic [lmx_pkg::STAMP_W-1:0]        req_stamp,
   input  lmx_pkg::cmd_type                   cmd,
   output lmx_pkg::sts_type                   sts,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [lmx_pkg::KIND_W-1:0]         rsp_kind,
   output logic [lmx_pkg::SITE_F_W-1:0]       rsp_dest,
   output logic [lmx_pkg::STAMP_W-1:0]        rsp_out_stamp,
   output logic                               rsp_last
);

   localparam int SITE_W = $clog2(NUM_SITES);
   localparam int CNT_W  = SITE_W + 1;
   localparam int RES_W  = lmx_pkg::RES_W;
   localparam int SW     = lmx_pkg::STAMP_W;
   localparam int FW     = lmx_pkg::SITE_F_W;

   // configuration and latched item
   logic [FW-1:0]                   my_site_ff;
   logic [lmx_pkg::MODE_W-1:0]      mode_ff;
   logic [FW-1:0]                   sender_ff;
   logic [SW-1:0]                   stamp_ff;
   logic [FW-1:0]                   me_ff;

   // node state
   logic [SW-1:0]                   clock_ff;
   logic [SW-1:0]                   pend_ff [NUM_SITES];
   logic [NUM_SITES-1:0]            grant_ff;
   logic                            requesting_ff;
   logic                            in_section_ff;

   // per-item results plan
   logic [lmx_pkg::KIND_W-1:0]      msg_kind_ff;
   logic [FW-1:0]                   msg_dest_ff;
   logic [SW-1:0]                   msg_stamp_ff;
   logic [CNT_W-1:0]                nmsg_ff;
   logic                            bcast_ff;
   logic                            skip_ff;
   logic [SW-1:0]                   entry_stamp_ff;
   logic [RES_W-1:0]                total_ff;
   logic [RES_W-1:0]                emit_idx_ff;

   // scan registers
   logic [SITE_W-1:0]               scan_idx_ff;
   logic [SITE_W-1:0]               best_idx_ff;
   logic [SW-1:0]                   best_val_ff;
   logic                            all_ff;

   // output register
   logic                            rsp_valid_ff;
   logic [lmx_pkg::KIND_W-1:0]      rsp_kind_ff;
   logic [FW-1:0]                   rsp_dest_ff;
   logic [SW-1:0]                   rsp_stamp_ff;
   logic                            rsp_last_ff;

   // decode signals
   logic                            bad_me;
   logic                            bad_sender;
   logic [SITE_W-1:0]               s_idx;
   logic [SITE_W-1:0]               m_idx;
   logic [SW-1:0]                   clk_p1;
   logic [SW-1:0]                   clk_p2;
   logic                            x_err;
   logic [CNT_W-1:0]                x_nmsg;
   logic [lmx_pkg::KIND_W-1:0]      x_kind;
   logic [FW-1:0]                   x_dest;
   logic [SW-1:0]                   x_stamp;
   logic                            x_bcast;
   logic [SW-1:0]                   x_clock;
   logic                            x_requesting;
   logic                            x_in_section;
   logic                            x_pend_we;
   logic [SITE_W-1:0]               x_pend_idx;
   logic [SW-1:0]                   x_pend_val;
   logic                            x_grant_set;
   logic                            x_grant_clr;

   // decide and emit signals
   logic                            enter;
   logic [CNT_W:0]                  sum_res;
   logic [RES_W-1:0]                total_in;
   logic                            emit_is_msg;
   logic [FW-1:0]                   bcast_dest;
   logic [SW-1:0]                   scan_val;
   logic                            slot_free;

   assign s_idx  = SITE_W'(sender_ff);
   assign m_idx  = SITE_W'(me_ff);
   assign bad_me = (32'(me_ff) >= NUM_SITES);
   assign bad_sender = (mode_ff <= lmx_pkg::MODE_RELEASE) &&
                       ((32'(sender_ff) >= NUM_SITES) || (sender_ff == me_ff));

   // saturating clock increments
   assign clk_p1 = (clock_ff >= lmx_pkg::CLOCK_MAX) ? lmx_pkg::CLOCK_MAX : clock_ff + 32'd1;
   assign clk_p2 = (clock_ff >= (lmx_pkg::CLOCK_MAX - 32'd1)) ? lmx_pkg::CLOCK_MAX
                                                             : clock_ff + 32'd2;

   // item decode: state update and message plan
   always_comb begin
      x_err        = 1'b0;
      x_nmsg       = '0;
      x_kind       = lmx_pkg::KIND_ERROR;
      x_dest       = '0;
      x_stamp      = '0;
      x_bcast      = 1'b0;
      x_clock      = clock_ff;
      x_requesting = requesting_ff;
      x_in_section = in_section_ff;
      x_pend_we    = 1'b0;
      x_pend_idx   = s_idx;
      x_pend_val   = lmx_pkg::NONE_STAMP;
      x_grant_set  = 1'b0;
      x_grant_clr  = 1'b0;
      if (bad_me || bad_sender) begin
         x_err = 1'b1;
      end else begin
         unique case (mode_ff)
            lmx_pkg::MODE_REQUEST: begin
               x_pend_we  = 1'b1;
               x_pend_val = (stamp_ff > lmx_pkg::CLOCK_MAX) ? lmx_pkg::CLOCK_MAX : stamp_ff;
               x_nmsg     = CNT_W'(1);
               x_kind     = lmx_pkg::KIND_REPLY;
               x_dest     = sender_ff;
               x_stamp    = clk_p1;
               x_clock    = clk_p2;
            end
            lmx_pkg::MODE_REPLY: begin
               if (!requesting_ff) begin
                  x_err = 1'b1;
               end else begin
                  x_grant_set = 1'b1;
                  x_clock     = clk_p1;
               end
            end
            lmx_pkg::MODE_RELEASE: begin
               x_pend_we = 1'b1;
               x_clock   = clk_p1;
            end
            lmx_pkg::MODE_ENTER: begin
               if (!requesting_ff) begin
                  x_requesting = 1'b1;
                  x_grant_set  = 1'b1;
                  x_pend_we    = 1'b1;
                  x_pend_idx   = m_idx;
                  x_pend_val   = clock_ff;
                  x_nmsg       = CNT_W'(NUM_SITES - 1);
                  x_kind       = lmx_pkg::KIND_REQUEST;
                  x_bcast      = 1'b1;
                  x_stamp      = clock_ff;
                  x_clock      = clk_p1;
               end
            end
            lmx_pkg::MODE_EXIT: begin
               if (in_section_ff) begin
                  x_in_section = 1'b0;
                  x_requesting = 1'b0;
                  x_grant_clr  = 1'b1;
                  x_pend_we    = 1'b1;
                  x_pend_idx   = m_idx;
                  x_nmsg       = CNT_W'(NUM_SITES - 1);
                  x_kind       = lmx_pkg::KIND_RELEASE;
                  x_bcast      = 1'b1;
                  x_stamp      = clock_ff;
                  x_clock      = clk_p1;
               end
            end
            default: begin
               x_err = 1'b0;
            end
         endcase
      end
      if (x_err) begin
         x_nmsg  = CNT_W'(1);
         x_kind  = lmx_pkg::KIND_ERROR;
         x_dest  = '0;
         x_stamp = '0;
      end
   end

   // entry check and result count
   assign enter    = !skip_ff && all_ff && (best_idx_ff == m_idx) &&
                     !in_section_ff && requesting_ff;
   assign sum_res  = (CNT_W+1)'(nmsg_ff) + (CNT_W+1)'(enter);
   assign total_in = (32'(sum_res) > lmx_pkg::MAX_RESULTS) ? RES_W'(lmx_pkg::MAX_RESULTS)
                                                           : RES_W'(sum_res);

   // result selection for the current emit index
   assign emit_is_msg = (32'(emit_idx_ff) < 32'(nmsg_ff));
   assign bcast_dest  = ({1'b0, me_ff} > emit_idx_ff) ? FW'(emit_idx_ff)
                                                       : FW'(emit_idx_ff + RES_W'(1));
   assign scan_val    = pend_ff[scan_idx_ff];
   assign slot_free   = !rsp_valid_ff || rsp_ready;

   // status to the controller; the scan still runs after a sender error
   assign sts.skip_scan  = bad_me;
   assign sts.scan_done  = (scan_idx_ff == SITE_W'(NUM_SITES - 1));
   assign sts.total_zero = (total_ff == '0);
   assign sts.slot_free  = slot_free;
   assign sts.emit_last  = (emit_idx_ff == (total_ff - RES_W'(1)));

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         my_site_ff <= '0;
      end else if (csr_wr_en) begin
         my_site_ff <= csr_wr_data;
      end
   end

   // item latch
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff   <= req_mode;
         sender_ff <= req_sender;
         stamp_ff  <= req_stamp;
         me_ff     <= my_site_ff;
      end
   end

   // node state: clock, flags, grants, pending stamps
   always_ff @(posedge clock) begin
      if (reset) begin
         clock_ff      <= '0;
         grant_ff      <= '0;
         requesting_ff <= 1'b0;
         in_section_ff <= 1'b0;
         for (int i = 0; i < NUM_SITES; i++) begin
            pend_ff[i] <= lmx_pkg::NONE_STAMP;
         end
      end else if (cmd.exec) begin
         clock_ff      <= x_clock;
         requesting_ff <= x_requesting;
         in_section_ff <= x_in_section;
         if (x_grant_clr) begin
            grant_ff <= '0;
         end else if (x_grant_set) begin
            grant_ff[(mode_ff == lmx_pkg::MODE_ENTER) ? m_idx : s_idx] <= 1'b1;
         end
         if (x_pend_we) begin
            pend_ff[x_pend_idx] <= x_pend_val;
         end
      end else if (cmd.decide && enter) begin
         in_section_ff <= 1'b1;
         clock_ff      <= clk_p1;
      end
   end

   // message plan
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         msg_kind_ff  <= x_kind;
         msg_dest_ff  <= x_dest;
         msg_stamp_ff <= x_stamp;
         nmsg_ff      <= x_nmsg;
         bcast_ff     <= x_bcast;
         skip_ff      <= bad_me;
      end
      if (cmd.decide) begin
         entry_stamp_ff <= clock_ff;
      end
   end

   // result counters
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff    <= '0;
         emit_idx_ff <= '0;
      end else if (cmd.decide) begin
         total_ff    <= total_in;
         emit_idx_ff <= '0;
      end else if (cmd.emit) begin
         emit_idx_ff <= emit_idx_ff + RES_W'(1);
      end
   end

   // site scan: all grants held and lowest stamp, ties to the lowest index
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_idx_ff <= '0;
      end else if (cmd.exec) begin
         scan_idx_ff <= '0;
      end else if (cmd.scan) begin
         scan_idx_ff <= scan_idx_ff + SITE_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         best_idx_ff <= '0;
         best_val_ff <= lmx_pkg::NONE_STAMP;
         all_ff      <= 1'b1;
      end else if (cmd.scan) begin
         all_ff <= all_ff & grant_ff[scan_idx_ff];
         if (scan_val < best_val_ff) begin
            best_idx_ff <= scan_idx_ff;
            best_val_ff <= scan_val;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_last_ff <= sts.emit_last;
         if (emit_is_msg) begin
            rsp_kind_ff  <= msg_kind_ff;
            rsp_dest_ff  <= bcast_ff ? bcast_dest : msg_dest_ff;
            rsp_stamp_ff <= msg_stamp_ff;
         end else begin
            rsp_kind_ff  <= lmx_pkg::KIND_ENTERED;
            rsp_dest_ff  <= '0;
            rsp_stamp_ff <= entry_stamp_ff;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_dest      = rsp_dest_ff;
   assign rsp_out_stamp = rsp_stamp_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

### hdl/lamport_mutex_node.sv
// lamport_mutex_node: top level of one node of distributed mutual exclusion
//
// req_ch takes one beat per item: a request, reply or release message from
// another site (sender, stamp) or a local enter or exit wish. rsp_ch gives
// the beats caused by that item: outgoing requests, replies and releases,
// an entered-section event, or an error; last marks the final beat of an item.
// csr_wr_en / csr_wr_data set this node's own site index; write it while idle.
// Steps: the accept cycle, execution of the item, a scan of all sites' grants and
// pending-stamp registers for the lowest pending stamp (skipped only when the
// site index is out of range), the entry decision, then one beat per cycle
// while the output register is free; an item may also give no beats at all.
// The last beat of an item sits in an output register, so the next item is
// taken while it waits; a stalled receiver holds the beat and pauses emission.
// Reset clears the logical clock, all grants and flags, marks every pending
// stamp as none and sets the site index to zero.
`timescale 1ns / 1ps

module lamport_mutex_node #(
   parameter int NUM_SITES = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [lmx_pkg::SITE_F_W-1:0]    csr_wr_data,
   lmx_req_if.sink                         req_ch,
   lmx_rsp_if.source                       rsp_ch
);

   lmx_pkg::cmd_type cmd;
   lmx_pkg::sts_type sts;
   logic             req_ready;

   // sequencer
   lmx_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   assign req_ch.ready = req_ready;

   // datapath
   lmx_dpath #(
      .NUM_SITES (NUM_SITES)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_mode      (req_ch.mode),
      .req_sender    (req_ch.sender),
      .req_stamp     (req_ch.stamp),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .rsp_kind      (rsp_ch.kind),
      .rsp_dest      (rsp_ch.dest),
      .rsp_out_stamp (rsp_ch.out_stamp),
      .rsp_last      (rsp_ch.last)
   );

endmodule

### hdl/lmx_checker.sv
// lmx_checker: port-level checks of the node, bound to the top level
`timescale 1ns / 1ps

module lmx_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [lmx_pkg::KIND_W-1:0]      rsp_kind,
   input logic [lmx_pkg::SITE_F_W-1:0]    rsp_dest,
   input logic [lmx_pkg::STAMP_W-1:0]     rsp_out_stamp,
   input logic                            rsp_last
);

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_dest) &&
      $stable(rsp_out_stamp) && $stable(rsp_last))
      else $error("stalled result beat changed");

   // one item at a time: input closes right after a beat is taken
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input stayed open after an accepted beat");

   // an error beat carries no destination or stamp
   a_error_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == lmx_pkg::KIND_ERROR |->
      rsp_dest == '0 && rsp_out_stamp == '0)
      else $error("malformed error beat");

   // entering the section is always the final beat of its item
   a_entered_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == lmx_pkg::KIND_ENTERED |-> rsp_last && rsp_dest == '0)
      else $error("entered beat not final");

   // no result survives reset
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind lamport_mutex_node lmx_checker u_lmx_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_kind      (rsp_ch.kind),
   .rsp_dest      (rsp_ch.dest),
   .rsp_out_stamp (rsp_ch.out_stamp),
   .rsp_last      (rsp_ch.last)
);
